@@ rtl/bb_pkg.sv @@
// Shared constants and types for the 19x19 RGBA box blur.
package bb_pkg;
   localparam int KERNEL    = 19;
   localparam int HALF_K    = KERNEL / 2;
   localparam int MAX_WIDTH = 1024;
   localparam int ROW_LIMIT = 4096;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 12;
   localparam int SLOT_W    = 5;
   localparam int WID_W     = 11;
   localparam int CS_W      = 13;
   localparam int WS_W      = 17;
   localparam int LS_DEPTH  = KERNEL * MAX_WIDTH;
   localparam int DIV_SHIFT = 25;
   localparam int PROD_W    = 34;
   localparam logic [WS_W-1:0]  RECIP     = 17'd92949;
   localparam logic [WID_W-1:0] WIDTH_RST = 11'd640;

   typedef struct packed {
      logic [CS_W-1:0] b;
      logic [CS_W-1:0] g;
      logic [CS_W-1:0] r;
   } csum_type;

   typedef struct packed {
      logic [WS_W-1:0] b;
      logic [WS_W-1:0] g;
      logic [WS_W-1:0] r;
   } wsum_type;

   typedef struct packed {
      logic first_row;
      logic sub_row;
      logic col0;
      logic sub_col;
      logic emit;
   } flags_type;
endpackage

@@ rtl/bb_if.sv @@
// Request and response channel interfaces of the box blur.
interface bb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;
   logic       frame_start;
   modport source (output valid, red_in, green_in, blue_in, alpha_in, frame_start,
                   input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, frame_start,
                   output ready);
endinterface

interface bb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;
   logic [7:0]  alpha_out;
   logic [9:0]  centre_col;
   logic [11:0] centre_row;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, centre_col,
                   centre_row, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, centre_col,
                   centre_row, output ready);
endinterface

@@ rtl/bb_cell.sv @@
// One cell of the column-sum history chain.
module bb_cell (
   input  logic             clock,
   input  logic             shift,
   input  bb_pkg::csum_type d,
   output bb_pkg::csum_type q
);
   import bb_pkg::*;
   csum_type q_ff;
   always_ff @(posedge clock) begin
      if (shift) begin
         q_ff <= d;
      end
   end
   assign q = q_ff;
endmodule

@@ rtl/bb_mean.sv @@
// Divide a window sum by 361 through a registered reciprocal multiply.
module bb_mean (
   input  logic                    clock,
   input  logic                    en,
   input  logic [bb_pkg::WS_W-1:0] sum,
   output logic [7:0]              mean
);
   import bb_pkg::*;
   logic [PROD_W-1:0] prod_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(sum) * PROD_W'(RECIP);
      end
   end
   assign mean = prod_ff[DIV_SHIFT+7:DIV_SHIFT];
endmodule

@@ rtl/box_blur_19x19_rgba_top.sv @@
// Top level of the 19x19 RGBA box blur.
//
// req_if takes one RGBA pixel word per cycle in raster order while rsp_if
// is not stalled; frame_start places the word at row 0, column 0. The image
// width (reset 640) is set by csr_we/csr_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. rsp_if
// gives one word per pixel that completes a 19x19 window: the floor mean of
// red, green, blue, the centre alpha, and the centre position. Border pixels
// give no word. A result passes the s1, s2 and s3 registers before rsp valid.
// Throughput: one pixel per cycle while rsp_if is not stalled, set by the
// line store (two reads, one write per cycle) and the column-sum memory (one
// read, one write per cycle); horizontal sums use a 19-cell column-sum chain.
// Reset clears position, width register and pipeline valids; memories
// keep their contents. A stalled rsp_if holds the whole pipeline and
// req_if.ready drops in the same cycle.
module box_blur_19x19_rgba_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [bb_pkg::WID_W-1:0]  csr_wdata,
   bb_req_if.sink                    req_if,
   bb_rsp_if.source                  rsp_if
);
   import bb_pkg::*;

   logic [WID_W-1:0]  width_ff;
   logic [WID_W-1:0]  width_eff;
   logic [COL_W-1:0]  col_ff, col_in, col_cur;
   logic [ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [SLOT_W-1:0] slot_ff, slot_in, slot_cur, slot_c;
   logic              adv, acc;
   logic [31:0]       pix;

   logic [31:0]       line_mem [LS_DEPTH];
   csum_type          cs_mem [MAX_WIDTH];

   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [23:0]       s1_pix_ff;
   flags_type         s1_flags_ff;
   logic [23:0]       s1_old_ff;
   logic [7:0]        s1_alpha_ff;
   csum_type          s1_cs_ff;

   logic              last_valid_ff;
   logic [COL_W-1:0]  last_col_ff;
   csum_type          last_cs_ff;

   csum_type          cs_old, cs_base, cs_new;
   logic [23:0]       minus;
   wsum_type          hsum_ff, hsum_in;
   csum_type          chain [KERNEL+1];
   csum_type          drop;

   logic              s2_valid_ff, s2_emit_ff;
   wsum_type          s2_sum_ff;
   logic [7:0]        s2_alpha_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic [ROW_W-1:0]  s2_row_ff;

   logic              s3_valid_ff;
   logic [7:0]        s3_alpha_ff;
   logic [COL_W-1:0]  s3_col_ff;
   logic [ROW_W-1:0]  s3_row_ff;
   logic              s2_go;

   assign adv = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;
   assign acc = req_if.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RST;
      end else if (csr_we) begin
         width_ff <= csr_wdata;
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff == '0) width_eff = WID_W'(1);
      if (width_ff > WID_W'(MAX_WIDTH)) width_eff = WID_W'(MAX_WIDTH);
      col_cur  = req_if.frame_start ? '0 : col_ff;
      row_cur  = req_if.frame_start ? '0 : row_ff;
      slot_cur = req_if.frame_start ? '0 : slot_ff;
      slot_c   = (slot_cur >= SLOT_W'(HALF_K)) ? slot_cur - SLOT_W'(HALF_K)
                                               : slot_cur + SLOT_W'(KERNEL - HALF_K);
      col_in  = col_cur + COL_W'(1);
      row_in  = row_cur;
      slot_in = slot_cur;
      if ((WID_W'(col_cur) + WID_W'(1)) >= width_eff) begin
         col_in = '0;
         if (row_cur < ROW_W'(ROW_LIMIT - 1)) begin
            row_in  = row_cur + ROW_W'(1);
            slot_in = (slot_cur == SLOT_W'(KERNEL - 1)) ? '0 : slot_cur + SLOT_W'(1);
         end
      end
      pix = {req_if.alpha_in, req_if.blue_in, req_if.green_in, req_if.red_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (acc) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // line store: read-first on the write address, second port for the centre
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_old_ff   <= line_mem[{slot_cur, col_cur}][23:0];
         s1_alpha_ff <= line_mem[{slot_c, col_cur - COL_W'(HALF_K)}][31:24];
         line_mem[{slot_cur, col_cur}] <= pix;
         s1_cs_ff    <= cs_mem[col_cur];
      end
      if (adv && s1_valid_ff) begin
         cs_mem[s1_col_ff] <= cs_new;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff             <= col_cur;
         s1_row_ff             <= row_cur;
         s1_pix_ff             <= pix[23:0];
         s1_flags_ff.first_row <= row_cur == '0;
         s1_flags_ff.sub_row   <= row_cur >= ROW_W'(KERNEL);
         s1_flags_ff.col0      <= col_cur == '0;
         s1_flags_ff.sub_col   <= col_cur >= COL_W'(KERNEL);
         s1_flags_ff.emit      <= (row_cur >= ROW_W'(KERNEL - 1)) &&
                                  (col_cur >= COL_W'(KERNEL - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc;
         if (s1_valid_ff) begin
            last_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         last_col_ff <= s1_col_ff;
         last_cs_ff  <= cs_new;
      end
   end

   always_comb begin
      cs_old  = (last_valid_ff && last_col_ff == s1_col_ff) ? last_cs_ff : s1_cs_ff;
      cs_base = s1_flags_ff.first_row ? '0 : cs_old;
      minus   = s1_flags_ff.sub_row ? s1_old_ff : '0;
      cs_new.r = cs_base.r - CS_W'(minus[7:0])   + CS_W'(s1_pix_ff[7:0]);
      cs_new.g = cs_base.g - CS_W'(minus[15:8])  + CS_W'(s1_pix_ff[15:8]);
      cs_new.b = cs_base.b - CS_W'(minus[23:16]) + CS_W'(s1_pix_ff[23:16]);
      drop     = s1_flags_ff.sub_col ? chain[KERNEL] : '0;
      hsum_in.r = (s1_flags_ff.col0 ? '0 : hsum_ff.r) + WS_W'(cs_new.r) - WS_W'(drop.r);
      hsum_in.g = (s1_flags_ff.col0 ? '0 : hsum_ff.g) + WS_W'(cs_new.g) - WS_W'(drop.g);
      hsum_in.b = (s1_flags_ff.col0 ? '0 : hsum_ff.b) + WS_W'(cs_new.b) - WS_W'(drop.b);
   end

   assign s2_go = adv && s1_valid_ff;
   assign chain[0] = cs_new;

   genvar gi;
   generate
      for (gi = 0; gi < KERNEL; gi++) begin : g_hist
         bb_cell u_cell (
            .clock (clock),
            .shift (s2_go),
            .d     (chain[gi]),
            .q     (chain[gi+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff <= '0;
      end else if (s2_go) begin
         hsum_ff <= hsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_flags_ff.emit;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_emit_ff  <= s1_flags_ff.emit;
         s2_sum_ff   <= hsum_in;
         s2_alpha_ff <= s1_alpha_ff;
         s2_col_ff   <= s1_col_ff - COL_W'(HALF_K);
         s2_row_ff   <= s1_row_ff - ROW_W'(HALF_K);
         s3_alpha_ff <= s2_alpha_ff;
         s3_col_ff   <= s2_col_ff;
         s3_row_ff   <= s2_row_ff;
      end
   end

   bb_mean u_mean_r (.clock(clock), .en(adv), .sum(s2_sum_ff.r), .mean(rsp_if.red_out));
   bb_mean u_mean_g (.clock(clock), .en(adv), .sum(s2_sum_ff.g), .mean(rsp_if.green_out));
   bb_mean u_mean_b (.clock(clock), .en(adv), .sum(s2_sum_ff.b), .mean(rsp_if.blue_out));

   assign rsp_if.valid      = s3_valid_ff;
   assign rsp_if.alpha_out  = s3_alpha_ff;
   assign rsp_if.centre_col = s3_col_ff;
   assign rsp_if.centre_row = s3_row_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(KERNEL)) else $error("slot out of range");
   a_centre_col: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.centre_col < COL_W'(MAX_WIDTH - HALF_K))
      else $error("centre column out of range");
   a_emit_flag: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_emit_ff) else $error("result without full window");
endmodule

@@ dv/bb_tb_if.sv @@
`timescale 1ns / 100ps
// Testbench package with the expected result word type.
package bb_tb_pkg;
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [9:0]  col;
      logic [11:0] row;
   } blur_word_type;
endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Box blur testbench: streams raster frames, predicts each window mean, checks every word.
module testbench;
   import bb_pkg::*;
   import bb_tb_pkg::*;

   localparam int MODE_RANDOM  = 0;
   localparam int MODE_MAX     = 1;
   localparam int MODE_ZERO    = 2;
   localparam int MODE_CHECKER = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [WID_W-1:0] csr_wdata = '0;

   bb_req_if req_if ();
   bb_rsp_if rsp_if ();

   box_blur_19x19_rgba_top DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_if(req_if), .rsp_if(rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0] pixel_rows [KERNEL][MAX_WIDTH];
   int unsigned width_reg = 640;
   int unsigned at_col, at_row;
   blur_word_type blur_expect_q [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_len = 0;
   int hold_tag = 0;
   int hold_seen = 0;
   int hold_cycles = 0;
   longint cycle_count = 0;

   function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] a, logic fs);
      int unsigned w, col, row, slot, sr, sg, sb, s;
      logic [31:0] p;
      blur_word_type e;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (fs) begin
         at_col = 0;
         at_row = 0;
      end
      col = at_col;
      row = at_row;
      if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
      slot = row % KERNEL;
      pixel_rows[slot][col] = {a, b, g, r};
      if (row >= KERNEL - 1 && col >= KERNEL - 1) begin
         sr = 0;
         sg = 0;
         sb = 0;
         for (int k = 0; k < KERNEL; k++) begin
            s = (slot + KERNEL - k) % KERNEL;
            for (int c = col + 1 - KERNEL; c <= col; c++) begin
               p = pixel_rows[s][c];
               sr += p[7:0];
               sg += p[15:8];
               sb += p[23:16];
            end
         end
         s = (slot + KERNEL - HALF_K) % KERNEL;
         p = pixel_rows[s][col - HALF_K];
         e.red = 8'(sr / (KERNEL * KERNEL));
         e.green = 8'(sg / (KERNEL * KERNEL));
         e.blue = 8'(sb / (KERNEL * KERNEL));
         e.alpha = p[31:24];
         e.col = COL_W'(col - HALF_K);
         e.row = ROW_W'(row - HALF_K);
         blur_expect_q = {blur_expect_q, e};
      end
      if (col + 1 >= w) begin
         at_col = 0;
         if (at_row < ROW_LIMIT - 1) at_row++;
      end else begin
         at_col = col + 1;
      end
   endfunction

   // receiver stall and long hold-off
   always @(negedge clock) begin
      if (hold_tag != hold_seen) begin
         hold_seen <= hold_tag;
         hold_cycles <= hold_len;
         rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      blur_word_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("testbench: FAIL");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (blur_expect_q.size() == 0) begin
            $display("%0t: unexpected word exp none act col %0d row %0d", $time,
                     rsp_if.centre_col, rsp_if.centre_row);
            errors++;
         end else begin
            e = blur_expect_q.pop_front();
            if (e != {rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out, rsp_if.alpha_out,
                      rsp_if.centre_col, rsp_if.centre_row}) begin
               $display("%0t: mismatch exp %h act %h", $time, e,
                        {rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out,
                         rsp_if.alpha_out, rsp_if.centre_col, rsp_if.centre_row});
               errors++;
            end
         end
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.red_in <= r;
      req_if.green_in <= g;
      req_if.blue_in <= b;
      req_if.alpha_in <= a;
      req_if.frame_start <= fs;
      do @(posedge clock); while (!(req_if.ready && req_if.valid));
      predict_pixel(r, g, b, a, fs);
      @(negedge clock);
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      while (blur_expect_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_width(int unsigned w);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= WID_W'(w);
      @(negedge clock);
      csr_we <= 1'b0;
      width_reg = w & 11'h7FF;
   endtask

   // start marks the first word of the frame; otherwise rows continue the frame
   task automatic send_frame(int rows, int mode, logic start);
      logic [7:0] v;
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      for (int y = 0; y < rows; y++)
         for (int x = 0; x < w; x++) begin
            case (mode)
               MODE_MAX: v = 8'hFF;
               MODE_ZERO: v = 8'h00;
               MODE_CHECKER: v = ((x ^ y) & 1) ? 8'hFF : 8'h00;
               default: v = 8'($urandom_range(255));
            endcase
            send_pixel(mode == MODE_RANDOM ? 8'($urandom_range(255)) : v,
                       mode == MODE_RANDOM ? 8'($urandom_range(255)) : ~v,
                       mode == MODE_RANDOM ? 8'($urandom_range(255)) : v,
                       8'($urandom_range(255)), start && x == 0 && y == 0);
         end
   endtask

   task automatic test_extremes;
      set_width(19);
      send_frame(19, MODE_MAX, 1'b1);
      send_frame(19, MODE_ZERO, 1'b0);
      send_frame(4, MODE_CHECKER, 1'b0);
   endtask

   task automatic test_narrow_width;
      set_width(0);
      repeat (5) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      set_width(18);
      send_frame(2, MODE_RANDOM, 1'b1);
   endtask

   task automatic test_random_frames;
      int mix [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{7, 7}};
      set_width(24);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = mix[ph][0];
         recv_stall_pct = mix[ph][1];
         send_frame(ph == 0 ? 25 : 6, MODE_RANDOM, ph == 0);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // continues the frame of test_random_frames at the same width
   task automatic test_backpressure;
      drain();
      hold_len = 200;
      hold_tag++;
      send_frame(8, MODE_RANDOM, 1'b0);
      drain();
      send_frame(2, MODE_RANDOM, 1'b0);
   endtask

   task automatic test_wide;
      set_width(2047);
      for (int i = 0; i < 40; i++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), i == 0);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.red_in = '0;
      req_if.green_in = '0;
      req_if.blue_in = '0;
      req_if.alpha_in = '0;
      req_if.frame_start = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_narrow_width();
      test_random_frames();
      test_backpressure();
      test_wide();
      drain();
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule
